// ----- design/lbs_pkg.sv -----
// shared types, constants and helpers for the linear blend skinning block
`default_nettype none
package lbs_pkg;

    localparam int WORD_W      = 32;
    localparam int MAT_ENTRIES = 16;
    localparam int POSE_USED   = 12;
    localparam int MEM_DEPTH   = 64;
    localparam int SLOT_W      = 6;
    localparam int IDX_W       = 8;
    localparam int WEIGHT_W    = 16;
    localparam int WIDE_W      = 66;
    localparam int WSHIFT      = 15;
    localparam int S_TDATA_W   = 240;
    localparam int M_TDATA_W   = 96;

    localparam logic       CMD_LOAD = 1'b0;
    localparam logic       CMD_SKIN = 1'b1;
    localparam logic [7:0] NO_BONE  = 8'd255;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        logic  clip;
        word_t val;
    } sat_t;

    function automatic sat_t sat32(input logic signed [WIDE_W-1:0] v);
        sat_t r;
        r.clip = 1'b0;
        r.val  = v[WORD_W-1:0];
        if (v > WIDE_W'(signed'(32'h7fffffff))) begin
            r.clip = 1'b1;
            r.val  = 32'h7fffffff;
        end else if (v < WIDE_W'(signed'(32'h80000000))) begin
            r.clip = 1'b1;
            r.val  = 32'h80000000;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/linear_blend_skinning.sv -----
// linear blend skinning engine with bone palette and seven stage pipeline
`default_nettype none
// Takes one beat per cycle, load or vertex, unless back pressure holds s_tready low. A load
// beat (tuser 0) writes one palette entry and gives no result. A vertex beat (tuser 1) passes
// the palette read register, then bind multiply, bind sum, pose multiply, pose sum, weight
// multiply and the final sum into the output register, which drives its result beat.
// The palette is held in one copy per influence so that all bones of a vertex read at once.
// Every stage holds its beat when the next one is full and cannot advance, so back pressure loses nothing.
module linear_blend_skinning #(
    parameter int BONE_SLOTS = 64,
    parameter int INFLUENCES = 4,
    parameter int FRAC_BITS  = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // pos_x, pos_y, pos_z, bone_indices, bone_weights, load_bone, load_entry, load_value
    input  wire [lbs_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  wire [0:0]                    s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // out_x, out_y, out_z
    output logic [lbs_pkg::M_TDATA_W-1:0] m_tdata,
    // clipped
    output logic [0:0]                   m_tuser
);
    import lbs_pkg::*;

    localparam int NI = INFLUENCES;
    localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

    // input fields
    logic [SLOT_W-1:0] load_bone;
    logic [4:0]        load_entry;
    word_t             load_value;
    logic              wr_en;
    assign load_bone  = s_tdata[197:192];
    assign load_entry = s_tdata[202:198];
    assign load_value = s_tdata[234:203];
    assign wr_en = s_tvalid && s_tready && (s_tuser[0] == CMD_LOAD)
                   && ({2'b00, load_bone} < IDX_W'(BONE_SLOTS));

    logic adv1, adv2, adv3, adv4, adv5, adv6, adv7;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;

    assign adv7 = !v7_reg || m_tready;
    assign adv6 = !v6_reg || adv7;
    assign adv5 = !v5_reg || adv6;
    assign adv4 = !v4_reg || adv5;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign s_tready = adv1;

    // stage 1: palette read
    word_t             bind_rd_reg [NI][MAT_ENTRIES];
    word_t             pose_rd_reg [NI][MAT_ENTRIES];
    word_t             pos1_reg    [3];
    logic [IDX_W-1:0]  idx1_reg    [NI];
    logic [WEIGHT_W-1:0] w1_reg    [NI];

    genvar gk, ge;
    generate
        for (gk = 0; gk < NI; gk++) begin : g_inf
            for (ge = 0; ge < MAT_ENTRIES; ge++) begin : g_ent
                word_t bind_mem [MEM_DEPTH];
                word_t pose_mem [MEM_DEPTH];
                always_ff @(posedge aclk) begin
                    if (wr_en && (load_entry[3:0] == 4'(ge))) begin
                        if (load_entry[4]) begin
                            bind_mem[load_bone] <= load_value;
                        end else begin
                            pose_mem[load_bone] <= load_value;
                        end
                    end
                    if (adv1) begin
                        bind_rd_reg[gk][ge] <= bind_mem[s_tdata[96+8*gk +: SLOT_W]];
                        pose_rd_reg[gk][ge] <= pose_mem[s_tdata[96+8*gk +: SLOT_W]];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (adv1) begin
            pos1_reg[0] <= s_tdata[31:0];
            pos1_reg[1] <= s_tdata[63:32];
            pos1_reg[2] <= s_tdata[95:64];
            for (int k = 0; k < NI; k++) begin
                idx1_reg[k] <= s_tdata[96+8*k +: IDX_W];
                w1_reg[k]   <= s_tdata[128+16*k +: WEIGHT_W];
            end
        end
    end

    // identity substitution for missing (NO_BONE) or out-of-range bones
    word_t bind_sel  [NI][MAT_ENTRIES];
    word_t pose_next [NI][POSE_USED];
    word_t vec1      [4];
    always_comb begin
        logic none;
        vec1[0] = pos1_reg[0];
        vec1[1] = pos1_reg[1];
        vec1[2] = pos1_reg[2];
        vec1[3] = ONE;
        for (int k = 0; k < NI; k++) begin
            none = (idx1_reg[k] == NO_BONE)
                   || ({1'b0, idx1_reg[k]} >= 9'(BONE_SLOTS));
            for (int e = 0; e < MAT_ENTRIES; e++) begin
                bind_sel[k][e] = none ? (((e / 4) == (e % 4)) ? ONE : '0)
                                      : bind_rd_reg[k][e];
            end
            for (int e = 0; e < POSE_USED; e++) begin
                pose_next[k][e] = none ? (((e / 4) == (e % 4)) ? ONE : '0)
                                       : pose_rd_reg[k][e];
            end
        end
    end

    // stage 2: bind products
    logic signed [63:0]  prod2_reg [NI][MAT_ENTRIES];
    word_t               pose2_reg [NI][POSE_USED];
    logic [WEIGHT_W-1:0] w2_reg    [NI];
    always_ff @(posedge aclk) begin
        if (adv2) begin
            for (int k = 0; k < NI; k++) begin
                for (int e = 0; e < MAT_ENTRIES; e++) begin
                    prod2_reg[k][e] <= bind_sel[k][e] * vec1[e % 4];
                end
                pose2_reg[k] <= pose_next[k];
                w2_reg[k]    <= w1_reg[k];
            end
        end
    end

    // stage 3: bind row sums
    sat_t t_next [NI][4];
    always_comb begin
        logic signed [WIDE_W-1:0] acc;
        for (int k = 0; k < NI; k++) begin
            for (int i = 0; i < 4; i++) begin
                acc = '0;
                for (int j = 0; j < 4; j++) begin
                    acc = acc + WIDE_W'(prod2_reg[k][i*4+j] >>> FRAC_BITS);
                end
                t_next[k][i] = sat32(acc);
            end
        end
    end

    word_t               t3_reg    [NI][4];
    word_t               pose3_reg [NI][POSE_USED];
    logic [WEIGHT_W-1:0] w3_reg    [NI];
    logic                clip3_reg;
    always_ff @(posedge aclk) begin
        if (adv3) begin
            clip3_reg <= 1'b0;
            for (int k = 0; k < NI; k++) begin
                for (int i = 0; i < 4; i++) begin
                    t3_reg[k][i] <= t_next[k][i].val;
                    if (t_next[k][i].clip) begin
                        clip3_reg <= 1'b1;
                    end
                end
                pose3_reg[k] <= pose2_reg[k];
                w3_reg[k]    <= w2_reg[k];
            end
        end
    end

    // stage 4: pose products
    logic signed [63:0]  prod4_reg [NI][POSE_USED];
    logic [WEIGHT_W-1:0] w4_reg    [NI];
    logic                clip4_reg;
    always_ff @(posedge aclk) begin
        if (adv4) begin
            clip4_reg <= clip3_reg;
            for (int k = 0; k < NI; k++) begin
                for (int e = 0; e < POSE_USED; e++) begin
                    prod4_reg[k][e] <= pose3_reg[k][e] * t3_reg[k][e % 4];
                end
                w4_reg[k] <= w3_reg[k];
            end
        end
    end

    // stage 5: pose row sums
    sat_t s_next [NI][3];
    always_comb begin
        logic signed [WIDE_W-1:0] acc;
        for (int k = 0; k < NI; k++) begin
            for (int i = 0; i < 3; i++) begin
                acc = '0;
                for (int j = 0; j < 4; j++) begin
                    acc = acc + WIDE_W'(prod4_reg[k][i*4+j] >>> FRAC_BITS);
                end
                s_next[k][i] = sat32(acc);
            end
        end
    end

    word_t               s5_reg [NI][3];
    logic [WEIGHT_W-1:0] w5_reg [NI];
    logic                clip5_reg;
    always_ff @(posedge aclk) begin
        if (adv5) begin
            clip5_reg <= clip4_reg;
            for (int k = 0; k < NI; k++) begin
                for (int i = 0; i < 3; i++) begin
                    s5_reg[k][i] <= s_next[k][i].val;
                    if (s_next[k][i].clip) begin
                        clip5_reg <= 1'b1;
                    end
                end
                w5_reg[k] <= w4_reg[k];
            end
        end
    end

    // stage 6: weight products
    logic signed [48:0] wp6_reg [NI][3];
    logic               clip6_reg;
    always_ff @(posedge aclk) begin
        if (adv6) begin
            clip6_reg <= clip5_reg;
            for (int k = 0; k < NI; k++) begin
                for (int i = 0; i < 3; i++) begin
                    wp6_reg[k][i] <= $signed({1'b0, w5_reg[k]}) * s5_reg[k][i];
                end
            end
        end
    end

    // stage 7: blend and output register
    sat_t  o_next [3];
    logic  clip_next;
    always_comb begin
        logic signed [50:0] acc;
        logic signed [50:0] sh;
        clip_next = clip6_reg;
        for (int i = 0; i < 3; i++) begin
            acc = '0;
            for (int k = 0; k < NI; k++) begin
                acc = acc + 51'(wp6_reg[k][i]);
            end
            sh = acc >>> WSHIFT;
            o_next[i] = sat32(WIDE_W'(sh));
            clip_next = clip_next | o_next[i].clip;
        end
    end

    logic [M_TDATA_W-1:0] out_reg;
    logic                 clip7_reg;
    always_ff @(posedge aclk) begin
        if (adv7) begin
            out_reg   <= {o_next[2].val, o_next[1].val, o_next[0].val};
            clip7_reg <= clip_next;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_tvalid && (s_tuser[0] == CMD_SKIN);
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
            if (adv5) v5_reg <= v4_reg;
            if (adv6) v6_reg <= v5_reg;
            if (adv7) v7_reg <= v6_reg;
        end
    end

    assign m_tvalid   = v7_reg;
    assign m_tdata    = out_reg;
    assign m_tuser[0] = clip7_reg;

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser[0] == CMD_LOAD)) |=> !v1_reg)
        else $error("load beat entered the vertex pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !adv1) |=> v1_reg)
        else $error("stalled vertex dropped from first stage");

    a_mid_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && adv4) |=> v4_reg)
        else $error("vertex lost between bind and pose stages");

endmodule
`default_nettype wire

// ----- verif/tb_linear_blend_skinning.sv -----
// testbench for the linear blend skinning block: scoreboard with a palette predictor
`timescale 1ns / 1ps
module tb_linear_blend_skinning;
    import lbs_pkg::*;

    localparam int FRAC = 16;

    typedef struct {
        word_t x;
        word_t y;
        word_t z;
        bit    clip;
    } skinned_t;

    class skin_scoreboard;
        word_t    pose_mem [1024];
        word_t    rest_mem [1024];
        bit       pose_set [1024];
        bit       rest_set [1024];
        skinned_t pending [$];
        int       errors = 0;

        function bit bone_ready(int b);
            for (int e = 0; e < 16; e++) begin
                if (!pose_set[b*16+e] || !rest_set[b*16+e]) return 0;
            end
            return 1;
        endfunction

        function longint mat_el(int b, int e, bit rest);
            if (b >= 64) return ((e >> 2) == (e & 3)) ? (64'sd1 <<< FRAC) : 0;
            return rest ? longint'(rest_mem[b*16+e]) : longint'(pose_mem[b*16+e]);
        endfunction

        function word_t clamp(longint v, inout bit c);
            if (v > 64'sd2147483647) begin
                c = 1;
                return 32'h7fffffff;
            end
            if (v < -64'sd2147483648) begin
                c = 1;
                return 32'h80000000;
            end
            return word_t'(v);
        endfunction

        function void note_beat(bit cmd, logic [S_TDATA_W-1:0] d);
            skinned_t r;
            word_t    p [4];
            word_t    t [4];
            word_t    s [3];
            longint   acc [3];
            longint   sum;
            int       b, w, e;
            if (cmd == CMD_LOAD) begin
                b = d[197:192];
                e = d[202:198];
                if (e < 16) begin
                    pose_mem[b*16+e] = d[234:203];
                    pose_set[b*16+e] = 1;
                end else begin
                    rest_mem[b*16+e-16] = d[234:203];
                    rest_set[b*16+e-16] = 1;
                end
                return;
            end
            p[0] = d[31:0];
            p[1] = d[63:32];
            p[2] = d[95:64];
            p[3] = 32'sh10000;
            r.clip = 0;
            acc = '{0, 0, 0};
            for (int k = 0; k < 4; k++) begin
                b = d[96+8*k +: 8];
                w = d[128+16*k +: 16];
                for (int i = 0; i < 4; i++) begin
                    sum = 0;
                    for (int j = 0; j < 4; j++)
                        sum += (mat_el(b, i*4+j, 1) * longint'(p[j])) >>> FRAC;
                    t[i] = clamp(sum, r.clip);
                end
                for (int i = 0; i < 3; i++) begin
                    sum = 0;
                    for (int j = 0; j < 4; j++)
                        sum += (mat_el(b, i*4+j, 0) * longint'(t[j])) >>> FRAC;
                    s[i] = clamp(sum, r.clip);
                    acc[i] += longint'(w) * longint'(s[i]);
                end
            end
            r.x = clamp(acc[0] >>> WSHIFT, r.clip);
            r.y = clamp(acc[1] >>> WSHIFT, r.clip);
            r.z = clamp(acc[2] >>> WSHIFT, r.clip);
            pending = {pending, r};
        endfunction

        function void check_vertex(logic [M_TDATA_W-1:0] d, bit c);
            skinned_t r;
            if (pending.size() == 0) begin
                $error("unexpected result beat %h", d);
                errors++;
                return;
            end
            r = pending.pop_front();
            if (d[31:0] !== r.x) begin
                $error("out_x expected %h got %h", r.x, d[31:0]);
                errors++;
            end
            if (d[63:32] !== r.y) begin
                $error("out_y expected %h got %h", r.y, d[63:32]);
                errors++;
            end
            if (d[95:64] !== r.z) begin
                $error("out_z expected %h got %h", r.z, d[95:64]);
                errors++;
            end
            if (c !== r.clip) begin
                $error("clipped expected %0d got %0d", r.clip, c);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    skin_scoreboard sb = new;
    int unsigned    cyc = 0;
    int             rx_stall = 0;

    linear_blend_skinning uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("[linear_blend_skinning] ERROR");
        $finish;
    end

    function int gap_len();
        int r;
        if ((cyc / 400) % 3 == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 0;
        end else begin
            m_tready <= 1;
            if ($urandom_range(0, 3) == 0) rx_stall <= gap_len();
        end
        if (aresetn && m_tvalid && m_tready) sb.check_vertex(m_tdata, m_tuser[0]);
    end

    task automatic send_beat(bit cmd, logic [S_TDATA_W-1:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= cmd;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(cmd, d);
    endtask

    task automatic load_entry(int b, int e, word_t v);
        send_beat(CMD_LOAD, {5'b0, v, 5'(e), 6'(b), 64'b0, 32'b0, 96'b0});
    endtask

    task automatic skin_vertex(word_t x, word_t y, word_t z, logic [31:0] idx,
                               logic [63:0] wts);
        send_beat(CMD_SKIN, {5'b0, 32'b0, 5'b0, 6'b0, wts, idx, z, y, x});
    endtask

    function word_t rand_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return $urandom;
        if (r < 4) return ($urandom_range(0, 1) ? 32'sh10000 : 32'sh0);
        return word_t'($urandom) >>> 12;
    endfunction

    function word_t rand_pos();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return word_t'($urandom) >>> 8;
    endfunction

    task automatic fill_bone(int b);
        for (int e = 0; e < 32; e++) load_entry(b, e, rand_value());
    endtask

    task automatic random_vertex();
        int          ready [$];
        logic [31:0] idx;
        logic [63:0] wts;
        int          r;
        for (int b = 0; b < 64; b++) if (sb.bone_ready(b)) ready = {ready, b};
        for (int k = 0; k < 4; k++) begin
            r = $urandom_range(0, 9);
            if (r < 6 && ready.size() > 0)
                idx[8*k +: 8] = 8'(ready[$urandom_range(0, ready.size() - 1)]);
            else if (r < 8)
                idx[8*k +: 8] = NO_BONE;
            else
                idx[8*k +: 8] = 8'($urandom_range(64, 254));
        end
        if ($urandom_range(0, 1)) wts = {$urandom, $urandom};
        else wts = {16'd0, 16'h2000, 16'h2000, 16'h4000};
        skin_vertex(rand_pos(), rand_pos(), rand_pos(), idx, wts);
    endtask

    initial begin
        int r;
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // bone 0: identity with translation, bone 63: extreme entries
        for (int e = 0; e < 32; e++)
            load_entry(0, e, ((e & 15) >> 2) == (e & 3) ? 32'sh10000 :
                             ((e & 3) == 3 ? 32'sh30000 : 32'sh0));
        for (int e = 0; e < 32; e++)
            load_entry(63, e, e[0] ? 32'sh80000000 : 32'sh7fffffff);
        skin_vertex(32'sh10000, -32'sh20000, 32'sh5, 32'hffffffff, 64'h8000800080008000);
        skin_vertex(32'sh12345, 32'sh777, -32'sh1, 32'hff80fe40, 64'hffffffffffffffff);
        skin_vertex(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'h00000000,
                    64'hffffffffffffffff);
        skin_vertex(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'h00000000,
                    64'hffffffffffffffff);
        skin_vertex(32'sh10000, 32'sh10000, 32'sh10000, 32'hff3fff3f, 64'h0000000000008000);
        skin_vertex(32'sh10000, 32'sh10000, 32'sh10000, 32'h3f3f3f3f, 64'h0);
        skin_vertex(-32'sh1, 32'sh0, 32'sh1, 32'h00ff643f, 64'h0001800000017fff);
        skin_vertex(32'sh55555555, 32'shaaaaaaaa, 32'sh0, 32'h00000000, 64'h0);

        for (int n = 0; n < 265; n++) begin
            r = $urandom_range(0, 99);
            if (r < 5)
                fill_bone($urandom_range(0, 63));
            else if (r < 30)
                load_entry($urandom_range(0, 63), $urandom_range(0, 31), rand_value());
            else
                random_vertex();
        end
        s_tvalid <= 0;

        while (sb.pending.size() > 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (sb.errors == 0)
            $display("[linear_blend_skinning] OK");
        else
            $display("[linear_blend_skinning] ERROR");
        $finish;
    end

endmodule
